// ===== sv/tsc_pkg.sv =====
// Shared constants, types and fixed-point formats of the Taylor sine/cosine block.
package tsc_pkg;

	// Defaults for the top-level parameters.
	localparam int TERMS_DEF      = 30;
	localparam int ANGLE_FRAC_DEF = 24;

	// Port widths.
	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;

	// Function select codes.
	localparam logic OP_SINE   = 1'b0;
	localparam logic OP_COSINE = 1'b1;

	// Internal format: 40 fraction bits. The reduced angle is below 2*pi < 2^43.
	localparam int IFRAC    = 40;
	localparam int OUT_FRAC = 30;
	localparam int X_W      = 43;
	localparam logic [X_W-1:0] TWO_PI_Q40 = 43'h6487ED5110B;

	// Series terms stay below 2^47 for any angle in [0, 2*pi).
	localparam int T_W    = 48;
	localparam int ACC_W  = T_W + X_W;
	localparam int P_W    = ACC_W - 1 - IFRAC;
	localparam int SUM_W  = 52;

	// Partial-product split of the term by reduced-angle multiply.
	localparam int T_LO_W = T_W / 2;
	localparam int X_LO_W = 22;
	localparam int X_HI_W = X_W - X_LO_W;
	localparam int PP_W   = T_LO_W + X_LO_W;

	// Digit divider: eight quotient bits per cycle.
	localparam int DIV_BPC   = 8;
	localparam int DIV_STEPS = (P_W + DIV_BPC - 1) / DIV_BPC;
	localparam int DVD_W     = DIV_STEPS * DIV_BPC;

	// Depth of the queue between range reduction and series evaluation.
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic           cosine;
		logic [X_W-1:0] x;
	} red_item_t;

	typedef struct packed {
		logic      valid;
		red_item_t item;
	} q_link_t;

endpackage

// ===== sv/taylor_sine_cosine.sv =====
// Top level of the Taylor series sine and cosine block.
//
// Usage: drive opcode (0 sine, 1 cosine) and a signed angle in radians with
// ANGLE_FRAC_BITS fraction bits, and raise start. A command transfer happens at
// the rising edge where start is high and busy is low. Each result appears on
// value while done is high for a single cycle; the receiver cannot stall it.
// The front end reduces the angle into [0, 2*pi): a truncated reciprocal of
// 2*pi gives a turn count that is low by at most one, the turns are multiplied
// out and subtracted, and one compare and subtract corrects the remainder. The
// reduced angle then goes to a two-entry queue. The back end evaluates every
// term with one shared multiplier (four partial products plus a pipeline
// register) and a divider that yields eight quotient bits per cycle, then
// accumulates the term. The series loop sets the sustained result rate.
// The front end keeps taking commands while the queue has room, so busy is
// high while an angle is being reduced or is waiting for room in the queue.
// Reset is asynchronous and active low; it empties the queue and returns both
// halves to idle, and any work in flight is dropped.
module taylor_sine_cosine import tsc_pkg::*; #(
	parameter int TERMS           = TERMS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      done,
	output logic signed [VALUE_W-1:0] value
);

	q_link_t push;
	q_link_t pop;
	logic    full;
	logic    pop_ready;

	// Command intake and range reduction.
	tsc_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.angle  (angle),
		.busy   (busy),
		.push   (push),
		.full   (full)
	);

	// Decouples the reduction from the series so each side can stall alone.
	tsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pop       (pop),
		.pop_ready (pop_ready)
	);

	// Series evaluation, rounding and saturation.
	tsc_series #(
		.TERMS(TERMS)
	) u_series (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.done      (done),
		.value     (value)
	);

endmodule

// ===== sv/tsc_front.sv =====
// Front end: accepts commands and reduces the angle into [0, 2*pi) by reciprocal multiplication.
module tsc_front import tsc_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      opcode,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      busy,
	output q_link_t                   push,
	input  logic                      full
);

	localparam int SHIFT = IFRAC - ANGLE_FRAC_BITS;
	localparam int MAG_W = ANGLE_W + SHIFT;
	localparam int QBITS = 30 - ANGLE_FRAC_BITS;
	localparam int EP_W  = ANGLE_W + QBITS;
	// Truncated reciprocal of 2*pi; the turn count it gives is low by at most one.
	localparam logic [63:0]      RECIP64 = (64'd1 << (ANGLE_W + SHIFT)) / 64'(TWO_PI_Q40);
	localparam logic [QBITS-1:0] RECIP   = RECIP64[QBITS-1:0];
	localparam logic [MAG_W-1:0] TURN    = MAG_W'(TWO_PI_Q40);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_EST  = 6'b000010,
		F_PROD = 6'b000100,
		F_SUB  = 6'b001000,
		F_FIX  = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	fstate_t            state_q;
	logic               neg_q;
	logic               cos_q;
	logic [MAG_W-1:0]   rem_q;
	logic [QBITS-1:0]   est_q;
	logic [MAG_W-1:0]   prod_q;

	logic [ANGLE_W-1:0] angle_u;
	logic [ANGLE_W-1:0] mag;
	logic [EP_W-1:0]    est_full;
	logic [X_W-1:0]     rem_x;

	assign angle_u  = angle;
	assign mag      = angle_u[ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;
	assign est_full = EP_W'(rem_q[MAG_W-1:SHIFT]) * EP_W'(RECIP);
	assign rem_x    = rem_q[X_W-1:0];

	assign busy       = (state_q != F_IDLE);
	assign push.valid = (state_q == F_PUSH);
	assign push.item.cosine = cos_q;
	// A negative angle with a nonzero remainder folds back from the top of the circle.
	assign push.item.x = (neg_q && (rem_x != '0)) ? (TWO_PI_Q40 - rem_x) : rem_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_EST;
					end
				end
				F_EST: begin
					state_q <= F_PROD;
				end
				F_PROD: begin
					state_q <= F_SUB;
				end
				F_SUB: begin
					state_q <= F_FIX;
				end
				F_FIX: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Estimate the whole turns, multiply them out, subtract, then correct once.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					neg_q <= angle_u[ANGLE_W-1];
					cos_q <= (opcode == OP_COSINE);
					rem_q <= {mag, {SHIFT{1'b0}}};
				end
			end
			F_EST: begin
				est_q <= est_full[EP_W-1:ANGLE_W];
			end
			F_PROD: begin
				prod_q <= MAG_W'(est_q) * TURN;
			end
			F_SUB: begin
				rem_q <= rem_q - prod_q;
			end
			F_FIX: begin
				if (rem_q >= TURN) begin
					rem_q <= rem_q - TURN;
				end
			end
			default: ;
		endcase
	end

	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_SUB) |-> (prod_q <= rem_q))
		else $error("turn estimate too high");

	a_fix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_FIX) |-> ({1'b0, rem_q} < {TURN, 1'b0}))
		else $error("turn estimate low by more than one");

	a_push_range: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (push.item.x < TWO_PI_Q40))
		else $error("reduced angle not below two pi");

endmodule

// ===== sv/tsc_queue.sv =====
// Short register queue between the range reduction and the series evaluation.
module tsc_queue import tsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_link_t push,
	output logic    full,
	output q_link_t pop,
	input  logic    pop_ready
);

	localparam int DEPTH = Q_DEPTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	red_item_t        mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop.valid = (cnt_q != '0);
	assign pop.item  = mem_q[rd_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop.valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

// ===== sv/tsc_series.sv =====
// Back end: sums the Maclaurin series with a shared multiplier and a digit divider.
module tsc_series import tsc_pkg::*; #(
	parameter int TERMS = TERMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  q_link_t                   pop,
	output logic                      pop_ready,
	output logic                      done,
	output logic signed [VALUE_W-1:0] value
);

	localparam int N_W    = $clog2(TERMS);
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int RSH    = IFRAC - OUT_FRAC;
	localparam int V_W    = SUM_W - RSH;
	localparam logic [2:0] PP_LAST = 3'd4;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << IFRAC;
	localparam logic signed [SUM_W-1:0] S_ONE  = SUM_W'(1) << IFRAC;
	localparam logic signed [SUM_W-1:0] S_HALF = SUM_W'(1) << (RSH - 1);
	localparam logic signed [V_W-1:0] V_ONE  = V_W'(1) << OUT_FRAC;
	localparam logic signed [V_W-1:0] V_MONE = -V_ONE;
	localparam logic signed [VALUE_W-1:0] OUT_ONE  = VALUE_W'(1) << OUT_FRAC;
	localparam logic signed [VALUE_W-1:0] OUT_MONE = -OUT_ONE;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL  = 5'b00010,
		B_DIV  = 5'b00100,
		B_ADD  = 5'b01000,
		B_FIN  = 5'b10000
	} bstate_t;

	bstate_t                   state_q;
	logic [N_W-1:0]            n_q;
	logic [2:0]                pp_q;
	logic [DCNT_W-1:0]         dcnt_q;
	logic                      done_q;

	logic                      cos_q;
	logic [X_W-1:0]            x_q;
	logic [T_W-1:0]            t_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [ACC_W-1:0]          acc_q;
	logic [PP_W-1:0]           prod_q;
	logic [1:0]                psel_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [N_W-1:0]            rem_q;
	logic [DVD_W-1:0]          quo_q;
	logic signed [VALUE_W-1:0] value_q;

	logic [T_LO_W-1:0]         t_half;
	logic [X_LO_W-1:0]         x_half;
	logic [PP_W-1:0]           prod_d;
	logic [ACC_W-1:0]          acc_add;
	logic [ACC_W-1:0]          acc_sum;
	logic [N_W-1:0]            div_r;
	logic [N_W:0]              div_x;
	logic [DIV_BPC-1:0]        div_qd;
	logic signed [SUM_W-1:0]   term_ext;
	logic                      term_used;
	logic signed [SUM_W-1:0]   rnd;
	logic signed [V_W-1:0]     v;
	logic signed [VALUE_W-1:0] v_sat;

	assign pop_ready = (state_q == B_IDLE);
	assign done      = done_q;
	assign value     = value_q;

	// Four partial products of at most 24 by 22 bits, one per cycle.
	assign t_half = pp_q[1] ? t_q[T_W-1:T_LO_W] : t_q[T_LO_W-1:0];
	assign x_half = pp_q[0] ? {{(X_LO_W - X_HI_W){1'b0}}, x_q[X_W-1:X_LO_W]}
	                        : x_q[X_LO_W-1:0];
	assign prod_d = PP_W'(t_half) * PP_W'(x_half);

	always_comb begin
		case (psel_q)
			2'd0:    acc_add = ACC_W'(prod_q);
			2'd1:    acc_add = ACC_W'(prod_q) << X_LO_W;
			2'd2:    acc_add = ACC_W'(prod_q) << T_LO_W;
			default: acc_add = ACC_W'(prod_q) << (T_LO_W + X_LO_W);
		endcase
	end

	assign acc_sum = acc_q + acc_add;

	// Restoring division by the term index, eight quotient bits per cycle.
	always_comb begin
		div_r  = rem_q;
		div_x  = '0;
		div_qd = '0;
		for (int i = 0; i < DIV_BPC; i++) begin
			div_x = {div_r, dvd_q[DVD_W-1-i]};
			if (div_x >= {1'b0, n_q}) begin
				div_r                 = N_W'(div_x - {1'b0, n_q});
				div_qd[DIV_BPC-1-i]   = 1'b1;
			end else begin
				div_r = div_x[N_W-1:0];
			end
		end
	end

	// Sine uses odd orders and cosine even ones; orders two and three modulo four subtract.
	assign term_ext  = $signed({{(SUM_W - T_W){1'b0}}, quo_q[T_W-1:0]});
	assign term_used = (n_q[0] != cos_q);

	// Round half up to Q2.30, then clamp to [-1, 1].
	assign rnd = sum_q + S_HALF;
	assign v   = V_W'(rnd >>> RSH);
	always_comb begin
		if (v > V_ONE) begin
			v_sat = OUT_ONE;
		end else if (v < V_MONE) begin
			v_sat = OUT_MONE;
		end else begin
			v_sat = VALUE_W'(v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			n_q     <= '0;
			pp_q    <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (pop.valid) begin
						n_q     <= N_W'(1);
						pp_q    <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					pp_q <= pp_q + 1'b1;
					if (pp_q == PP_LAST) begin
						dcnt_q  <= DCNT_W'(DIV_STEPS - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					pp_q <= '0;
					if (n_q == N_W'(TERMS - 1)) begin
						state_q <= B_FIN;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= B_MUL;
					end
				end
				B_FIN: begin
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop.valid) begin
					cos_q <= pop.item.cosine;
					x_q   <= pop.item.x;
					t_q   <= T_ONE;
					sum_q <= pop.item.cosine ? S_ONE : '0;
				end
			end
			B_MUL: begin
				if (pp_q != PP_LAST) begin
					prod_q <= prod_d;
					psel_q <= pp_q[1:0];
				end
				if (pp_q == '0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_sum;
				end
				if (pp_q == PP_LAST) begin
					dvd_q <= DVD_W'(acc_sum[ACC_W-2:IFRAC]);
					rem_q <= '0;
				end
			end
			B_DIV: begin
				rem_q <= div_r;
				dvd_q <= dvd_q << DIV_BPC;
				quo_q <= {quo_q[DVD_W-DIV_BPC-1:0], div_qd};
			end
			B_ADD: begin
				t_q <= quo_q[T_W-1:0];
				if (term_used) begin
					sum_q <= n_q[1] ? (sum_q - term_ext) : (sum_q + term_ext);
				end
			end
			B_FIN: begin
				value_q <= v_sat;
			end
			default: ;
		endcase
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (rem_q < n_q))
		else $error("divider remainder not below divisor");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((value_q <= OUT_ONE) && (value_q >= OUT_MONE)))
		else $error("result outside saturation range");

endmodule
